// ===== src/assert_macros.svh =====
// Concurrent assertion helpers; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property failed");

`define ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst_n, prop)

`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ===== src/csc_pkg.sv =====
package csc_pkg;

	localparam int COORD_W    = 20;
	localparam int NORM_W     = 12;
	localparam int OFF_W      = 28;
	localparam int DIST_W     = 40;
	localparam int T_W        = 17;
	localparam int T_FRAC     = 16;
	localparam int NUM_PLANES = 6;
	localparam int PIDX_W     = 3;
	localparam int MUL_A_W    = 18;
	localparam int MUL_B_W    = COORD_W + 1;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int STEP_W     = 3;
	localparam int MUL_STEPS  = 6;
	localparam int DCNT_W     = 5;
	localparam int CFG_W      = 64;
	localparam int ADDR_W     = 6;

	localparam logic [T_W-1:0] T_ONE = T_W'(1 << T_FRAC);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0]  norm_t;

	typedef struct packed {
		logic signed [OFF_W-1:0] off;
		norm_t                   nz;
		norm_t                   ny;
		norm_t                   nx;
	} plane_t;

	// which endpoint (or which t) and which axis a multiply step works on
	typedef struct packed {
		logic       hi;
		logic [1:0] ax;
	} step_sel_t;

	function automatic step_sel_t step_sel(input logic [STEP_W-1:0] s);
		step_sel_t r;
		case (s)
			3'd0:    r = '{hi: 1'b0, ax: 2'd0};
			3'd1:    r = '{hi: 1'b0, ax: 2'd1};
			3'd2:    r = '{hi: 1'b0, ax: 2'd2};
			3'd3:    r = '{hi: 1'b1, ax: 2'd0};
			3'd4:    r = '{hi: 1'b1, ax: 2'd1};
			3'd5:    r = '{hi: 1'b1, ax: 2'd2};
			default: r = '{hi: 1'b0, ax: 2'd0};
		endcase
		return r;
	endfunction

endpackage

// ===== src/convex_segment_clipper.sv =====
// Each plane runs S_LOAD, S_MUL, S_CLASS; a crossing plane adds 17 divide steps and S_UPD.
// A visible segment then runs S_LERP for the endpoint products and S_DONE for the hand-off;
// a rejected one stops at that plane and goes straight to S_DONE for the hand-off.
// Throughput: one item at a time; the next item is taken the cycle after the result is
// loaded, and the hand-off waits longer while an earlier result waits for ready.
// Reset (arst_n low) clears the plane registers to zero and empties the block.
`include "assert_macros.svh"

module convex_segment_clipper #(
	parameter int PLANE_COUNT = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [csc_pkg::ADDR_W-1:0]          paddr,
	input  logic [csc_pkg::CFG_W-1:0]           pwdata,
	output logic [csc_pkg::CFG_W-1:0]           prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  csc_pkg::coord_t                     start_x,
	input  csc_pkg::coord_t                     start_y,
	input  csc_pkg::coord_t                     start_z,
	input  csc_pkg::coord_t                     end_x,
	input  csc_pkg::coord_t                     end_y,
	input  csc_pkg::coord_t                     end_z,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                visible,
	output csc_pkg::coord_t                     clip_start_x,
	output csc_pkg::coord_t                     clip_start_y,
	output csc_pkg::coord_t                     clip_start_z,
	output csc_pkg::coord_t                     clip_end_x,
	output csc_pkg::coord_t                     clip_end_y,
	output csc_pkg::coord_t                     clip_end_z
);
	import csc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_MUL, S_CLASS, S_DIV, S_UPD, S_LERP, S_DONE
	} state_t;

	// configuration
	plane_t             plane_q [NUM_PLANES];
	logic [PIDX_W-1:0]  cfg_idx;
	logic               cfg_wr;

	// control
	state_t             state_q;
	logic [PIDX_W-1:0]  pidx_q;
	logic [STEP_W-1:0]  step_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic               vis_q;
	logic [T_W-1:0]     t0_q;
	logic [T_W-1:0]     t1_q;

	// datapath
	coord_t                     a_q [3];
	coord_t                     b_q [3];
	logic signed [PROD_W-1:0]   prod_s1;
	logic [STEP_W-1:0]          tag_s1;
	logic signed [DIST_W-1:0]   da_q;
	logic signed [DIST_W-1:0]   db_q;
	logic [DIST_W+1:0]          rem_q;
	logic [DIST_W:0]            den_q;
	logic [T_W-1:0]             quo_q;
	logic                       enter_q;
	coord_t                     res_q [MUL_STEPS];

	// combinational
	plane_t                     pl;
	step_sel_t                  sel;
	step_sel_t                  tsel;
	norm_t                      nrm;
	coord_t                     src;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [MUL_B_W-1:0]  dlt;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [DIST_W-1:0]   prod_ext;
	logic signed [DIST_W-1:0]   off_ext;
	logic signed [DIST_W:0]     diff;
	logic [DIST_W-1:0]          num;
	logic [DIST_W:0]            den;
	logic [DIST_W+1:0]          trial;
	logic                       ge;
	logic [T_W-1:0]             t0_n;
	logic [T_W-1:0]             t1_n;
	logic                       last_plane;
	logic [DIST_W-1:0]          rnd;
	coord_t                     lerp_c;
	logic                       out_free;
	logic                       out_zero;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:ADDR_W-PIDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (cfg_idx < PIDX_W'(NUM_PLANES)) begin
			prdata = plane_q[cfg_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_wr && cfg_idx < PIDX_W'(NUM_PLANES)) begin
			plane_q[cfg_idx] <= pwdata;
		end
	end

	assign item_ready = (state_q == S_IDLE);
	assign out_free   = !result_valid || result_ready;
	assign last_plane = (pidx_q == PIDX_W'(PLANE_COUNT - 1));
	assign out_zero   = clip_start_x == '0 && clip_start_y == '0 && clip_start_z == '0 &&
		clip_end_x == '0 && clip_end_y == '0 && clip_end_z == '0;

	assign pl      = plane_q[pidx_q];
	assign sel     = step_sel(step_q);
	assign tsel    = step_sel(tag_s1);
	assign off_ext = {{(DIST_W-OFF_W-10){pl.off[OFF_W-1]}}, pl.off, 10'b0};

	// shared multiplier: normal x coordinate for distances, t x (B-A) for endpoints
	always_comb begin
		src = sel.hi ? b_q[sel.ax] : a_q[sel.ax];
		dlt = {b_q[sel.ax][COORD_W-1], b_q[sel.ax]} - {a_q[sel.ax][COORD_W-1], a_q[sel.ax]};
		case (sel.ax)
			2'd0:    nrm = pl.nx;
			2'd1:    nrm = pl.ny;
			default: nrm = pl.nz;
		endcase
		if (state_q == S_LERP) begin
			mul_a = {1'b0, (sel.hi ? t1_q : t0_q)};
			mul_b = dlt;
		end else begin
			mul_a = {{(MUL_A_W-NORM_W){nrm[NORM_W-1]}}, nrm};
			mul_b = {src[COORD_W-1], src};
		end
	end

	assign mul_p    = mul_a * mul_b;
	assign prod_ext = {prod_s1[PROD_W-1], prod_s1};

	// crossing parameter setup
	always_comb begin
		diff = {da_q[DIST_W-1], da_q} - {db_q[DIST_W-1], db_q};
		den  = diff[DIST_W] ? (DIST_W+1)'(-diff) : diff;
		num  = da_q[DIST_W-1] ? DIST_W'(-da_q) : da_q;
	end

	// restoring divide step; the first step takes the integer bit without a shift
	always_comb begin
		trial = (dcnt_q == '0) ? rem_q : {rem_q[DIST_W:0], 1'b0};
		ge    = (trial >= {1'b0, den_q});
	end

	always_comb begin
		t0_n = (enter_q && quo_q > t0_q) ? quo_q : t0_q;
		t1_n = (!enter_q && quo_q < t1_q) ? quo_q : t1_q;
	end

	// round half up, then offset from A; low bits wrap exactly
	assign rnd    = prod_ext + DIST_W'(1 << (T_FRAC - 1));
	assign lerp_c = rnd[T_FRAC+COORD_W-1:T_FRAC] + a_q[tsel.ax];

	always_ff @(posedge clk) begin
		prod_s1 <= mul_p;
		tag_s1  <= step_q;
		unique case (state_q)
			S_IDLE: begin
				a_q[0] <= start_x;
				a_q[1] <= start_y;
				a_q[2] <= start_z;
				b_q[0] <= end_x;
				b_q[1] <= end_y;
				b_q[2] <= end_z;
				for (int i = 0; i < MUL_STEPS; i++) begin
					res_q[i] <= '0;
				end
			end
			S_LOAD: begin
				da_q <= off_ext;
				db_q <= off_ext;
			end
			S_MUL: begin
				if (step_q != '0) begin
					if (tsel.hi) begin
						db_q <= db_q + prod_ext;
					end else begin
						da_q <= da_q + prod_ext;
					end
				end
			end
			S_CLASS: begin
				rem_q   <= {2'b0, num};
				den_q   <= den;
				quo_q   <= '0;
				enter_q <= da_q[DIST_W-1];
			end
			S_DIV: begin
				rem_q <= ge ? trial - {1'b0, den_q} : trial;
				quo_q <= {quo_q[T_W-2:0], ge};
			end
			S_LERP: begin
				if (step_q != '0 && vis_q) begin
					res_q[tag_s1] <= lerp_c;
				end
			end
			S_UPD, S_DONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pidx_q       <= '0;
			step_q       <= '0;
			dcnt_q       <= '0;
			vis_q        <= 1'b0;
			t0_q         <= '0;
			t1_q         <= T_ONE;
			result_valid <= 1'b0;
			visible      <= 1'b0;
			clip_start_x <= '0;
			clip_start_y <= '0;
			clip_start_z <= '0;
			clip_end_x   <= '0;
			clip_end_y   <= '0;
			clip_end_z   <= '0;
		end else begin
			// S_DONE refills the output register itself
			if (result_valid && result_ready && state_q != S_DONE) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						pidx_q  <= '0;
						vis_q   <= 1'b1;
						t0_q    <= '0;
						t1_q    <= T_ONE;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MUL_STEPS)) begin
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					dcnt_q <= '0;
					if (!da_q[DIST_W-1] && !db_q[DIST_W-1]) begin
						// both inside: plane does not clip
						if (last_plane) begin
							step_q  <= '0;
							state_q <= S_LERP;
						end else begin
							pidx_q  <= pidx_q + 1'b1;
							state_q <= S_LOAD;
						end
					end else if (da_q[DIST_W-1] && db_q[DIST_W-1]) begin
						vis_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(T_W - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					t0_q <= t0_n;
					t1_q <= t1_n;
					if (t0_n > t1_n) begin
						vis_q   <= 1'b0;
						state_q <= S_DONE;
					end else if (last_plane) begin
						step_q  <= '0;
						state_q <= S_LERP;
					end else begin
						pidx_q  <= pidx_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_LERP: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MUL_STEPS)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						result_valid <= 1'b1;
						visible      <= vis_q;
						clip_start_x <= res_q[0];
						clip_start_y <= res_q[1];
						clip_start_z <= res_q[2];
						clip_end_x   <= res_q[3];
						clip_end_y   <= res_q[4];
						clip_end_z   <= res_q[5];
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

	`ASSERT_PROP(a_busy_after_accept, clk, arst_n, item_valid && item_ready |=> !item_ready)
	`ASSERT_PROP(a_reject_zero, clk, arst_n, result_valid && !visible |-> out_zero)
	`ASSERT_PROP(a_interval_order, clk, arst_n, state_q == S_LERP |-> t0_q <= t1_q)
	`ASSERT_PROP(a_div_rem, clk, arst_n, state_q == S_DIV |-> rem_q <= (DIST_W+2)'(den_q))
	`ASSERT_NEVER(a_t_range, clk, arst_n, t0_q > T_ONE || t1_q > T_ONE)

endmodule
